### rtl/iddn_pkg.sv
`timescale 1ns / 1ps

package iddn_pkg;

  localparam int unsigned NUM_CHARS  = 10;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned YEAR_W     = 14;  // 0..9999
  localparam int unsigned DOY_W      = 9;   // 0..365, March-based
  localparam int unsigned DAY_NUM_W  = 23;
  localparam int unsigned DASH_POS_A = 4;
  localparam int unsigned DASH_POS_B = 7;

  localparam logic [CHAR_W-1:0] DASH_CHAR = 8'h2D;
  localparam logic [CHAR_W-1:0] DIGIT_LO  = 8'h30;
  localparam logic [CHAR_W-1:0] DIGIT_HI  = 8'h39;

  localparam logic [3:0] MONTH_FEB = 4'd2;

  localparam int unsigned DAYS_PER_YEAR = 365;
  // 1970-01-01 counted from the March-based year 0 origin
  localparam int unsigned EPOCH_SHIFT   = 719468;
  // floor(x * RECIP_25 / 2^RECIP_SHIFT) == floor(x / 25) for x < 2500
  localparam int unsigned RECIP_25      = 1311;
  localparam int unsigned RECIP_SHIFT   = 15;

  typedef logic [NUM_CHARS-1:0][CHAR_W-1:0] iddn_chars_t;

  typedef struct packed {
    logic               ok;
    logic [YEAR_W-1:0]  yy;   // year, shifted back by one for Jan/Feb
    logic [DOY_W-1:0]   doy;  // day of the March-based year
  } iddn_fields_t;

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MONTH_FEB:                                   len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // (153 * mp + 2) / 5 for the March-based month index
  function automatic logic [DOY_W-1:0] month_start(input logic [3:0] mp);
    logic [DOY_W-1:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

### rtl/iddn_parse.sv
`timescale 1ns / 1ps

module iddn_parse
  import iddn_pkg::*;
(
  input  iddn_chars_t  chars_i,
  output iddn_fields_t fields_o
);

  logic             fmt_ok;
  logic [3:0]       dg [NUM_CHARS];
  logic [YEAR_W-1:0] year;
  logic [6:0]       century;
  logic [6:0]       yr2;
  logic [6:0]       month;
  logic [6:0]       day;
  logic             leap;
  logic [4:0]       mlen;
  logic             month_ok;
  logic             day_ok;
  logic [3:0]       mp;

  always_comb begin
    fmt_ok = 1'b1;
    for (int i = 0; i < NUM_CHARS; i++) begin
      dg[i] = chars_i[i][3:0];
      if (i == DASH_POS_A || i == DASH_POS_B) begin
        fmt_ok = fmt_ok & (chars_i[i] == DASH_CHAR);
      end else begin
        fmt_ok = fmt_ok & (chars_i[i] inside {[DIGIT_LO:DIGIT_HI]});
      end
    end
  end

  assign century = 7'(dg[0]) * 7'd10 + 7'(dg[1]);
  assign yr2     = 7'(dg[2]) * 7'd10 + 7'(dg[3]);
  assign year    = 14'(century) * 14'd100 + 14'(yr2);
  assign month   = 7'(dg[5]) * 7'd10 + 7'(dg[6]);
  assign day     = 7'(dg[8]) * 7'd10 + 7'(dg[9]);

  // century years are leap only when the century count divides by four
  assign leap = (yr2 == 7'd0) ? (century[1:0] == 2'd0) : (yr2[1:0] == 2'd0);

  assign month_ok = (month >= 7'd1) && (month <= 7'd12);
  assign mlen     = month_days(month[3:0], leap);
  assign day_ok   = (day >= 7'd1) && (day <= 7'(mlen));

  assign mp = (month > 7'(MONTH_FEB)) ? (month[3:0] - 4'd3) : (month[3:0] + 4'd9);

  always_comb begin
    fields_o.ok  = fmt_ok && (year != '0) && month_ok && day_ok;
    fields_o.yy  = (month <= 7'(MONTH_FEB)) ? (year - 14'd1) : year;
    fields_o.doy = month_start(mp) + 9'(day[4:0]) - 9'd1;
  end

endmodule

### rtl/iddn_days.sv
`timescale 1ns / 1ps

module iddn_days
  import iddn_pkg::*;
(
  input  iddn_fields_t                fields_i,
  output logic                        date_valid_o,
  output logic signed [DAY_NUM_W-1:0] day_number_o
);

  logic [YEAR_W-3:0]              q4;
  logic [YEAR_W-3+11:0]           q4_prod;
  logic [6:0]                     q100;
  logic [4:0]                     q400;
  logic [DAY_NUM_W-1:0]           pos;

  // era form folded: 146097 = 400*365 + 100 - 4 + 1
  assign q4      = fields_i.yy[YEAR_W-1:2];
  assign q4_prod = 23'(q4) * 23'(RECIP_25);
  assign q100    = q4_prod[RECIP_SHIFT +: 7];
  assign q400    = q100[6:2];

  assign pos = 23'(fields_i.yy) * 23'(DAYS_PER_YEAR) + 23'(q4) - 23'(q100)
             + 23'(q400) + 23'(fields_i.doy);

  assign date_valid_o = fields_i.ok;
  assign day_number_o = fields_i.ok ? $signed(pos - 23'(EPOCH_SHIFT)) : '0;

endmodule

### rtl/iso_date_to_day_number_core.sv
`timescale 1ns / 1ps
// Path: input register, then parse/day-count logic, then the result register that drives out_valid.
// Throughput: one date per cycle unless out_ready stalls; an input register feeds
// parse/day-count logic that lands in the output register, and in_ready stays high
// while that register drains or is free.
// Reset: synchronous active-low rst_n empties both stages; payload is not reset.

module iso_date_to_day_number_core
  import iddn_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_pos0_char,
  input  logic [7:0]                  in_pos1_char,
  input  logic [7:0]                  in_pos2_char,
  input  logic [7:0]                  in_pos3_char,
  input  logic [7:0]                  in_pos4_char,
  input  logic [7:0]                  in_pos5_char,
  input  logic [7:0]                  in_pos6_char,
  input  logic [7:0]                  in_pos7_char,
  input  logic [7:0]                  in_pos8_char,
  input  logic [7:0]                  in_pos9_char,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_date_valid,
  output logic signed [DAY_NUM_W-1:0] out_day_number
);

  logic                        s1_valid_r, s1_valid_nxt;
  iddn_chars_t                 s1_chars_r, s1_chars_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_date_valid_r, out_date_valid_nxt;
  logic signed [DAY_NUM_W-1:0] out_day_number_r, out_day_number_nxt;

  logic         in_xfer;
  logic         s1_adv;
  iddn_fields_t fields;
  logic         calc_valid;
  logic signed [DAY_NUM_W-1:0] calc_day;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  iddn_parse u_parse (
    .chars_i  (s1_chars_r),
    .fields_o (fields)
  );

  iddn_days u_days (
    .fields_i     (fields),
    .date_valid_o (calc_valid),
    .day_number_o (calc_day)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end

    s1_chars_nxt = s1_chars_r;
    if (in_xfer) begin
      s1_chars_nxt = {in_pos9_char, in_pos8_char, in_pos7_char, in_pos6_char, in_pos5_char,
                      in_pos4_char, in_pos3_char, in_pos2_char, in_pos1_char, in_pos0_char};
    end

    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    out_date_valid_nxt = s1_adv ? calc_valid : out_date_valid_r;
    out_day_number_nxt = s1_adv ? calc_day   : out_day_number_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_chars_r       <= s1_chars_nxt;
    out_date_valid_r <= out_date_valid_nxt;
    out_day_number_r <= out_day_number_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_date_valid = out_date_valid_r;
  assign out_day_number = out_day_number_r;

endmodule

### rtl/iddn_checker.sv
`timescale 1ns / 1ps

module iddn_checker
  import iddn_pkg::*;
(
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_date_valid,
  input logic signed [DAY_NUM_W-1:0] out_day_number
);

  // a stalled result holds its payload until the transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_date_valid)
                                && $stable(out_day_number))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_date_valid |-> out_day_number == '0)
    else $error("rejected date with nonzero day number");

  a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_date_valid |-> out_day_number >= -23'sd719162
                                    && out_day_number <= 23'sd2932896)
    else $error("day number outside calendar range");

endmodule

bind iso_date_to_day_number_core iddn_checker u_iddn_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_date_valid (out_date_valid),
  .out_day_number (out_day_number)
);
